>>> design/ianp_pkg.sv
// shared types, constants and register map of the index allocator
package ianp_pkg;

	localparam int BASE_W    = 16;
	localparam int COUNT_W   = 7;
	localparam int SLOTS_DEF = 64;
	localparam int CHUNK     = 32;
	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;

	localparam logic [BASE_W-1:0]  BASE_RESET  = 16'd0;
	localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

	// operation codes of a request
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	// register select, taken from paddr bit 2
	localparam logic REG_BASE_IDX  = 1'b0;
	localparam logic REG_COUNT_IDX = 1'b1;

	typedef struct packed {
		logic              op;
		logic [BASE_W-1:0] current_index;
	} in_item_t;

	typedef struct packed {
		logic              granted;
		logic [BASE_W-1:0] index;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic clear;
		logic take_pref;
		logic take_scan;
		logic fail;
		logic next_chunk;
		logic push;
	} cmd_t;

	typedef struct packed {
		logic is_clear;
		logic pref_hit;
		logic chunk_hit;
		logic last_chunk;
	} status_t;

endpackage

>>> design/ianp_ctrl.sv
// sequencing state machine of the index allocator
module ianp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  ianp_pkg::status_t status,
	output ianp_pkg::cmd_t    cmd
);
	import ianp_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_PREF,
		S_SCAN,
		S_FINISH
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.load = in_valid;
			end
			S_PREF: begin
				priority if (status.is_clear) begin
					cmd.clear = 1'b1;
				end else if (status.pref_hit) begin
					cmd.take_pref = 1'b1;
				end else begin
					// no decision yet, the chunk search follows
				end
			end
			S_SCAN: begin
				priority if (status.chunk_hit) begin
					cmd.take_scan = 1'b1;
				end else if (status.last_chunk) begin
					cmd.fail = 1'b1;
				end else begin
					cmd.next_chunk = 1'b1;
				end
			end
			S_FINISH: begin
				cmd.push = !out_valid || out_ready;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_PREF;
				end
				S_PREF: begin
					if (status.is_clear || status.pref_hit) state_q <= S_FINISH;
					else state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (status.chunk_hit || status.last_chunk) state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (cmd.push) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cmd.push) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	a_one_decision: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clear, cmd.take_pref, cmd.take_scan, cmd.fail}))
		else $error("more than one decision in a cycle");

	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (!out_valid || out_ready))
		else $error("result pushed over a waiting result");

	a_accept_pref: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_PREF))
		else $error("transfer not followed by successor check");

endmodule

>>> design/ianp_dp.sv
// taken bitmap, successor check, chunked free-slot search and result registers
module ianp_dp #(
	parameter int SLOTS = ianp_pkg::SLOTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ianp_pkg::cmd_t                 cmd,
	output ianp_pkg::status_t              status,
	input  ianp_pkg::in_item_t             in_data,
	input  logic [ianp_pkg::BASE_W-1:0]    base,
	input  logic [ianp_pkg::COUNT_W-1:0]   count,
	output ianp_pkg::out_item_t            out_data
);
	import ianp_pkg::*;

	// slot_count cannot reach beyond this, so no more bits are ever used
	localparam int MaxUse  = (1 << COUNT_W) - 1;
	localparam int MapBits = (SLOTS < MaxUse) ? SLOTS : MaxUse;
	localparam int SW      = $clog2(MapBits);
	localparam int CKW     = $clog2(CHUNK);
	localparam int NChunk  = (MapBits + CHUNK - 1) / CHUNK;
	localparam int CW      = (NChunk > 1) ? $clog2(NChunk) : 1;
	localparam int GW      = CW + CKW;

	logic [MapBits-1:0]       taken_q;
	logic                     op_q;
	logic [BASE_W-1:0]        cur_q;
	logic [CW-1:0]            chunk_q;
	logic                     res_granted_q;
	logic [BASE_W-1:0]        res_index_q;
	out_item_t                out_q;

	logic [COUNT_W-1:0]       n;
	logic [BASE_W-1:0]        diff;
	logic [BASE_W:0]          succ;
	logic                     pref_ok;
	logic [SW-1:0]            pref_slot;
	logic [MapBits-1:0]       free_v;
	logic [NChunk*CHUNK-1:0]  pad;
	logic [CHUNK-1:0]         chunk_v;
	logic                     hit;
	logic [CKW-1:0]           pos;
	logic [GW-1:0]            scan_slot;

	assign n = (count > COUNT_W'(MapBits)) ? COUNT_W'(MapBits) : count;

	// successor of the caller's index, only when it stays inside the range
	assign diff      = cur_q - base;
	assign succ      = {1'b0, diff} + (BASE_W + 1)'(1);
	assign pref_ok   = (cur_q >= base) && (succ < (BASE_W + 1)'(n));
	assign pref_slot = succ[SW-1:0];

	for (genvar p = 0; p < NChunk * CHUNK; p++) begin : g_pad
		if (p < MapBits) begin : g_used
			assign free_v[p] = (COUNT_W'(p) < n) && !taken_q[p];
			assign pad[p]    = free_v[p];
		end else begin : g_spare
			assign pad[p] = 1'b0;
		end
	end

	assign chunk_v = pad[{chunk_q, CKW'(0)} +: CHUNK];

	// lowest free slot in the current chunk
	always_comb begin
		hit = 1'b0;
		pos = '0;
		for (int j = CHUNK - 1; j >= 0; j--) begin
			if (chunk_v[j]) begin
				hit = 1'b1;
				pos = CKW'(j);
			end
		end
	end

	assign scan_slot = {chunk_q, pos};

	assign status.is_clear   = (op_q == OP_CLEAR);
	assign status.pref_hit   = (op_q == OP_ALLOC) && pref_ok && !taken_q[pref_slot];
	assign status.chunk_hit  = hit;
	assign status.last_chunk = (chunk_q == CW'(NChunk - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken_q <= '0;
			chunk_q <= '0;
		end else begin
			if (cmd.clear) taken_q <= '0;
			else if (cmd.take_pref) taken_q[pref_slot] <= 1'b1;
			else if (cmd.take_scan) taken_q[scan_slot[SW-1:0]] <= 1'b1;
			if (cmd.load) chunk_q <= '0;
			else if (cmd.next_chunk) chunk_q <= chunk_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= in_data.op;
			cur_q <= in_data.current_index;
		end
		if (cmd.take_pref) begin
			res_granted_q <= 1'b1;
			res_index_q   <= base + BASE_W'(pref_slot);
		end else if (cmd.take_scan) begin
			res_granted_q <= 1'b1;
			res_index_q   <= base + BASE_W'(scan_slot);
		end else if (cmd.clear || cmd.fail) begin
			res_granted_q <= 1'b0;
			res_index_q   <= '0;
		end
		if (cmd.push) begin
			out_q.granted <= res_granted_q;
			out_q.index   <= res_index_q;
		end
	end

	assign out_data = out_q;

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take_scan |-> (32'(scan_slot) < 32'(n)))
		else $error("search took a slot outside the range");

	a_pref_marked: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take_pref |=> taken_q[$past(pref_slot)])
		else $error("successor slot not marked taken");

	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> (taken_q == '0))
		else $error("bitmap not empty after clear");

endmodule

>>> design/index_allocator_next_preferred_unit.sv
// top level of the index allocator: register port, controller and datapath
// a request is taken in S_IDLE; S_PREF settles a clear or a free successor,
//   otherwise S_SCAN searches chunks of 32 slots, and S_FINISH hands the result on
// once the output register is free; a new request is taken only after that, and the
//   single 32-slot priority encoder walks the bitmap one chunk a cycle
// reset: all slots free, base_index 0, slot_count 64, no result pending
module index_allocator_next_preferred_unit #(
	parameter int SLOTS = ianp_pkg::SLOTS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// register port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ianp_pkg::ADDR_W-1:0]  paddr,
	input  logic [ianp_pkg::DATA_W-1:0]  pwdata,
	output logic [ianp_pkg::DATA_W-1:0]  prdata,
	output logic                         pready,
	// request channel
	input  logic                         in_valid,
	output logic                         in_ready,
	input  ianp_pkg::in_item_t           in_data,
	// result channel
	output logic                         out_valid,
	input  logic                         out_ready,
	output ianp_pkg::out_item_t          out_data
);
	import ianp_pkg::*;

	logic [BASE_W-1:0]  base_q;
	logic [COUNT_W-1:0] count_q;
	logic               wr_en;
	cmd_t               cmd;
	status_t            status;

	// register writes finish in the access phase, never stalled
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q  <= BASE_RESET;
			count_q <= COUNT_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_BASE_IDX:  base_q  <= pwdata[BASE_W-1:0];
				REG_COUNT_IDX: count_q <= pwdata[COUNT_W-1:0];
				default:       base_q  <= base_q;
			endcase
		end
	end

	// read back of the two registers, zero extended
	always_comb begin
		unique case (paddr[2])
			REG_BASE_IDX:  prdata = DATA_W'(base_q);
			REG_COUNT_IDX: prdata = DATA_W'(count_q);
			default:       prdata = '0;
		endcase
	end

	// controller: accepts a request only when idle, then checks the successor,
	// walks the chunks if needed and hands the result to the output register
	ianp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// datapath: bitmap, successor test, chunk search and result/output registers
	ianp_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.in_data  (in_data),
		.base     (base_q),
		.count    (count_q),
		.out_data (out_data)
	);

endmodule
